FILE: sv/madsr_pkg.sv
// Package for the multichannel ADSR envelope block: input mode codes, envelope
// phase codes, controller states, command/status structs and rate tables.
// No dependencies.
`default_nettype none

package madsr_pkg;

  localparam int unsigned VOL_W = 16;
  localparam int unsigned PROD_W = 32;

  localparam logic [VOL_W-1:0] FULL_SCALE_VAL = 16'd32768;
  localparam logic [VOL_W-1:0] SUSTAIN_SCALE = 16'd2184;
  localparam logic [VOL_W-1:0] END_FACTOR = 16'd3500;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MUL1   = 2'd1,
    ST_MUL2   = 2'd2,
    ST_COMMIT = 2'd3
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;    // input word accepted this cycle
    logic mul1;    // factor times table value
    logic mul2;    // span times new factor
    logic commit;  // write back channel state, load output word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_ch;
    logic out_free;
  } stat_t;

  function automatic logic [VOL_W-1:0] attack_step(input logic [3:0] idx);
    logic [VOL_W-1:0] v;
    unique case (idx)
      4'd0:  v = 16'd65535;
      4'd1:  v = 16'd16384;
      4'd2:  v = 16'd8192;
      4'd3:  v = 16'd5459;
      4'd4:  v = 16'd3449;
      4'd5:  v = 16'd2341;
      4'd6:  v = 16'd1928;
      4'd7:  v = 16'd1638;
      4'd8:  v = 16'd1311;
      4'd9:  v = 16'd524;
      4'd10: v = 16'd262;
      4'd11: v = 16'd164;
      4'd12: v = 16'd131;
      4'd13: v = 16'd44;
      4'd14: v = 16'd26;
      default: v = 16'd16;
    endcase
    return v;
  endfunction

  function automatic logic [VOL_W-1:0] fall_mult(input logic [3:0] idx);
    logic [VOL_W-1:0] v;
    unique case (idx)
      4'd0:  v = 16'd39779;
      4'd1:  v = 16'd57846;
      4'd2:  v = 16'd61571;
      4'd3:  v = 16'd62865;
      4'd4:  v = 16'd63836;
      4'd5:  v = 16'd64378;
      4'd6:  v = 16'd64581;
      4'd7:  v = 16'd64723;
      4'd8:  v = 16'd64885;
      4'd9:  v = 16'd65275;
      4'd10: v = 16'd65405;
      4'd11: v = 16'd65454;
      4'd12: v = 16'd65471;
      4'd13: v = 16'd65514;
      4'd14: v = 16'd65523;
      default: v = 16'd65528;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/madsr_in_if.sv
// Input channel of the envelope block: valid/ready plus one command word.
// Depends on nothing.
`default_nettype none

interface madsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] channel;
  logic       gate;
  logic [3:0] attack_rate;
  logic [3:0] decay_rate;
  logic [3:0] sustain_level;
  logic [3:0] release_rate;

  modport source (
    output valid, mode, channel, gate, attack_rate, decay_rate, sustain_level,
           release_rate,
    input  ready
  );

  modport sink (
    input  valid, mode, channel, gate, attack_rate, decay_rate, sustain_level,
           release_rate,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/madsr_out_if.sv
// Output channel of the envelope block: valid/ready plus one volume report.
// Depends on nothing.
`default_nettype none

interface madsr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  voice;
  logic [15:0] volume;
  logic [2:0]  phase;
  logic        last;

  modport source (
    output valid, voice, volume, phase, last,
    input  ready
  );

  modport sink (
    input  valid, voice, volume, phase, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/multichannel_adsr_envelope.sv
// Multichannel ADSR envelope generator, one envelope per voice.
// Input channel in_i takes one word per handshake: mode 0 loads gate, attack,
// decay, sustain and release of one channel (channels NUM_VOICES and up are
// dropped), mode 2 clears every gate, mode 1 is the millisecond tick, mode 3
// is ignored. Load and timeout words give no output.
// A tick gives NUM_VOICES words on out_o, one per channel in channel order,
// each with voice, volume, phase and last set on the final channel.
// Each channel takes two passes through the shared 16x16 multiplier, then
// the state update, so a tick keeps in_i.ready low from its acceptance
// until the final channel commits, also while stalled; a new tick is taken
// only after that. The first word is valid once the first channel has
// passed the MUL1, MUL2 and COMMIT states.
// The output word sits in a register: when the receiver stalls, the
// sequencer holds before committing the next channel, and a new input word
// is taken while the final word still waits.
// Reset clears all channel settings and envelopes to idle with volume zero.
// Depends on madsr_pkg, madsr_in_if, madsr_out_if, madsr_ctrl, madsr_datapath.
`default_nettype none

module multichannel_adsr_envelope #(
  parameter int unsigned NUM_VOICES = 3
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  madsr_in_if.sink  in_i,
  madsr_out_if.source out_o
);
  import madsr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  madsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  madsr_datapath #(
    .NUM_VOICES (NUM_VOICES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (in_i.mode),
    .channel_i       (in_i.channel),
    .gate_i          (in_i.gate),
    .attack_rate_i   (in_i.attack_rate),
    .decay_rate_i    (in_i.decay_rate),
    .sustain_level_i (in_i.sustain_level),
    .release_rate_i  (in_i.release_rate),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .voice_o         (out_o.voice),
    .volume_o        (out_o.volume),
    .phase_o         (out_o.phase),
    .last_o          (out_o.last)
  );

endmodule

`default_nettype wire

FILE: sv/madsr_ctrl.sv
// Sequencer of the envelope block: accepts input words and steps each channel
// through the MUL1 and MUL2 multiply states and a commit. Depends on madsr_pkg.
`default_nettype none

module madsr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_mode_i,
  output logic                 in_ready_o,
  input  madsr_pkg::stat_t     stat_i,
  output madsr_pkg::cmd_t      cmd_o
);
  import madsr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_mode_i == MODE_TICK) begin
            state_d = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the word
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.last_ch ? ST_IDLE : ST_MUL1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/madsr_datapath.sv
// Datapath of the envelope block: per-channel settings and envelope state,
// one shared 16x16 multiplier, the phase update and the output register.
// Depends on madsr_pkg.
`default_nettype none

module madsr_datapath #(
  parameter int unsigned NUM_VOICES = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  madsr_pkg::cmd_t         cmd_i,
  output madsr_pkg::stat_t        stat_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [1:0]         channel_i,
  input  wire logic               gate_i,
  input  wire logic [3:0]         attack_rate_i,
  input  wire logic [3:0]         decay_rate_i,
  input  wire logic [3:0]         sustain_level_i,
  input  wire logic [3:0]         release_rate_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              voice_o,
  output logic [15:0]             volume_o,
  output logic [2:0]              phase_o,
  output logic                    last_o
);
  import madsr_pkg::*;

  localparam int unsigned CH_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_VOICES - 1);

  logic             gate_q    [NUM_VOICES];
  logic [3:0]       atk_q     [NUM_VOICES];
  logic [3:0]       dec_q     [NUM_VOICES];
  logic [3:0]       rel_q     [NUM_VOICES];
  logic [VOL_W-1:0] sus_q     [NUM_VOICES];
  phase_e           phase_q   [NUM_VOICES];
  logic [VOL_W-1:0] vol_q     [NUM_VOICES];
  logic [VOL_W-1:0] start_q   [NUM_VOICES];
  logic [VOL_W-1:0] factor_q  [NUM_VOICES];

  logic [CH_W-1:0]   ch_q;
  logic [PROD_W-1:0] prod_q;
  logic [VOL_W-1:0]  newfac_q;

  logic             out_valid_q;
  logic [1:0]       voice_q;
  logic [VOL_W-1:0] volume_q;
  logic [2:0]       phase_out_q;
  logic             last_q;

  // current channel view
  logic             g;
  phase_e           ph;
  logic [VOL_W-1:0] vol, sus;
  logic [3:0]       dec;

  logic [VOL_W-1:0] mul_a, mul_b;
  logic [VOL_W-1:0] fac_new;
  logic [VOL_W-1:0] prod_vol;
  logic [VOL_W:0]   sum;
  logic [VOL_W-1:0] target;

  phase_e           ph_d;
  logic [VOL_W-1:0] vol_d, start_d, factor_d;

  logic             load_hit;
  logic [CH_W-1:0]  load_idx;

  assign g   = gate_q[ch_q];
  assign ph  = phase_q[ch_q];
  assign vol = vol_q[ch_q];
  assign sus = sus_q[ch_q];
  assign dec = dec_q[ch_q];

  assign load_hit = cmd_i.take && (mode_i == MODE_LOAD) &&
                    (5'(channel_i) < 5'(NUM_VOICES));
  assign load_idx = CH_W'(channel_i);

  // shared multiplier operands
  assign fac_new = prod_q[PROD_W-1:VOL_W];
  always_comb begin
    if (cmd_i.mul2) begin
      mul_a = (ph == PH_DECAY) ? (FULL_SCALE_VAL - sus) : start_q[ch_q];
      mul_b = fac_new;
    end else begin
      mul_a = factor_q[ch_q];
      mul_b = fall_mult((ph == PH_DECAY) ? dec : rel_q[ch_q]);
    end
  end

  // product of a value below 2^16 and a factor below 1.0, shifted by 15
  assign prod_vol = prod_q[30:15];

  assign sum    = {1'b0, vol} + {1'b0, attack_step(atk_q[ch_q])};
  assign target = (dec != 4'd0) ? FULL_SCALE_VAL : sus;

  always_comb begin
    ph_d     = ph;
    vol_d    = vol;
    start_d  = start_q[ch_q];
    factor_d = factor_q[ch_q];
    unique case (ph)
      PH_ATTACK: begin
        if (!g) begin
          ph_d     = PH_RELEASE;
          start_d  = vol;
          factor_d = FULL_SCALE_VAL;
        end else if (sum >= {1'b0, target}) begin
          ph_d     = (dec != 4'd0) ? PH_DECAY : PH_SUSTAIN;
          factor_d = FULL_SCALE_VAL;
          vol_d    = target;
        end else begin
          vol_d = sum[VOL_W-1:0];
        end
      end
      PH_DECAY: begin
        if (!g) begin
          ph_d     = PH_RELEASE;
          start_d  = vol;
          factor_d = FULL_SCALE_VAL;
        end else begin
          factor_d = newfac_q;
          if (newfac_q <= END_FACTOR) begin
            ph_d  = PH_SUSTAIN;
            vol_d = sus;
          end else begin
            vol_d = sus + prod_vol;
          end
        end
      end
      PH_SUSTAIN: begin
        if (!g) begin
          ph_d     = PH_RELEASE;
          start_d  = vol;
          factor_d = FULL_SCALE_VAL;
        end
      end
      PH_RELEASE: begin
        if (g) begin
          ph_d     = PH_ATTACK;
          start_d  = vol;
          factor_d = FULL_SCALE_VAL;
        end else begin
          factor_d = newfac_q;
          if (newfac_q <= END_FACTOR) begin
            ph_d  = PH_IDLE;
            vol_d = '0;
          end else begin
            vol_d = prod_vol;
          end
        end
      end
      default: begin
        ph_d  = g ? PH_ATTACK : PH_IDLE;
        vol_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1 || cmd_i.mul2) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.mul2) begin
      newfac_q <= fac_new;
    end
    if (cmd_i.commit) begin
      voice_q     <= 2'(ch_q);
      volume_q    <= vol_d;
      phase_out_q <= ph_d;
      last_q      <= (ch_q == LAST_CH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        gate_q[i]   <= 1'b0;
        atk_q[i]    <= '0;
        dec_q[i]    <= '0;
        rel_q[i]    <= '0;
        sus_q[i]    <= '0;
        phase_q[i]  <= PH_IDLE;
        vol_q[i]    <= '0;
        start_q[i]  <= '0;
        factor_q[i] <= '0;
      end
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_hit) begin
        gate_q[load_idx] <= gate_i;
        atk_q[load_idx]  <= attack_rate_i;
        dec_q[load_idx]  <= decay_rate_i;
        rel_q[load_idx]  <= release_rate_i;
        sus_q[load_idx]  <= VOL_W'(sustain_level_i) * SUSTAIN_SCALE;
      end
      if (cmd_i.take && (mode_i == MODE_TIMEOUT)) begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          gate_q[i] <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        phase_q[ch_q]  <= ph_d;
        vol_q[ch_q]    <= vol_d;
        start_q[ch_q]  <= start_d;
        factor_q[ch_q] <= factor_d;
        // advance to the next channel, wrap after the last
        ch_q <= (ch_q == LAST_CH) ? '0 : ch_q + CH_W'(1);
      end
    end
  end

  assign stat_o.last_ch  = (ch_q == LAST_CH);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign voice_o     = voice_q;
  assign volume_o    = volume_q;
  assign phase_o     = phase_out_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
